### hdl/kth_free_slot_insertion_order_core_defines.svh
// Assertion macros for the free-slot insertion order core.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef KTH_FREE_SLOT_INSERTION_ORDER_CORE_DEFINES_SVH
`define KTH_FREE_SLOT_INSERTION_ORDER_CORE_DEFINES_SVH

// Same-cycle implication, ignored during reset
`define KFS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored during reset
`define KFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/kfs_pkg.sv
// Shared types and constants for the free-slot insertion order core.
// No dependencies.
`default_nettype none

package kfs_pkg;

  localparam int POS_W = 6;
  localparam int VAL_W = 16;
  localparam int CMP_W = POS_W + 1;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] item_value;
    logic             is_final;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] slot_index;
    logic [VAL_W-1:0] slot_value;
    logic             end_of_line;
  } slot_t;

  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,
    S_BUILD   = 6'b000010,
    S_FETCH   = 6'b000100,
    S_DESCEND = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_SHOW    = 6'b100000
  } state_t;

  typedef struct packed {
    logic accept;
    logic build_step;
    logic fetch;
    logic descend;
    logic emit_rd;
    logic emit_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic build_last;
    logic desc_last;
    logic last_item;
    logic emit_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### hdl/kfs_ctrl.sv
// Sequencer for the free-slot insertion order core: load, build, descend, emit.
// Depends on kfs_pkg.
`default_nettype none

module kfs_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  input  wire                 item_final,
  input  wire                 slot_stall,
  input  kfs_pkg::ctrl_sts_t  sts,
  output logic                item_stall,
  output logic                slot_valid,
  output kfs_pkg::ctrl_cmd_t  cmd
);

  kfs_pkg::state_t state, state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kfs_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and the next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      kfs_pkg::S_LOAD: begin
        cmd.accept = item_valid;
        if (item_valid && item_final) state_next = kfs_pkg::S_BUILD;
      end
      kfs_pkg::S_BUILD: begin
        cmd.build_step = 1'b1;
        if (sts.build_last) state_next = kfs_pkg::S_FETCH;
      end
      kfs_pkg::S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = kfs_pkg::S_DESCEND;
      end
      kfs_pkg::S_DESCEND: begin
        cmd.descend = 1'b1;
        if (sts.desc_last) begin
          state_next = sts.last_item ? kfs_pkg::S_EMIT_RD : kfs_pkg::S_FETCH;
        end
      end
      kfs_pkg::S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = kfs_pkg::S_SHOW;
      end
      kfs_pkg::S_SHOW: begin
        if (!slot_stall) begin
          cmd.emit_adv = 1'b1;
          state_next   = sts.emit_last ? kfs_pkg::S_LOAD : kfs_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_next = kfs_pkg::S_LOAD;
      end
    endcase
  end

  assign item_stall = (state != kfs_pkg::S_LOAD);
  assign slot_valid = (state == kfs_pkg::S_SHOW);

endmodule

`default_nettype wire

### hdl/kfs_datapath.sv
// Datapath: item store, left-count tree, arranged line and their counters.
// Depends on kfs_pkg; driven by kfs_ctrl commands.
`default_nettype none

module kfs_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  kfs_pkg::item_t      item,
  input  kfs_pkg::ctrl_cmd_t  cmd,
  output kfs_pkg::ctrl_sts_t  sts,
  output kfs_pkg::slot_t      slot
);

  localparam int POS_W  = kfs_pkg::POS_W;
  localparam int VAL_W  = kfs_pkg::VAL_W;
  localparam int CMP_W  = kfs_pkg::CMP_W;
  localparam int LEVELS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEAVES = 1 << LEVELS;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW     = LEVELS + 1;

  // Stores
  logic [POS_W+VAL_W-1:0] item_mem [CAPACITY];
  logic [LEVELS-1:0]      free_count_tree [LEAVES];
  logic [VAL_W-1:0]       line_mem [CAPACITY];

  logic [POS_W+VAL_W-1:0] entry_q;
  logic [LEVELS-1:0]      tree_q;
  logic [VAL_W-1:0]       line_q;

  logic [CW-1:0]     count, count_inc, n_items, remain, remain_m1, emit_idx;
  logic [LW-1:0]     lvl, dlev;
  logic [LEVELS-1:0] off, off_max, node_b, left_b;
  logic [LEVELS-1:0] node, rank, rank_cur, rank_next, child;
  logic [AW-1:0]     lo, half, span, n_ext;
  logic [CMP_W-1:0]  pos_e, im1_e;
  logic              go_left, build_last, desc_last;

  // Load: keep the item while there is room
  assign count_inc = (count < CW'(CAPACITY)) ? count + CW'(1) : count;

  always_ff @(posedge clk) begin
    if (cmd.accept && (count < CW'(CAPACITY))) begin
      item_mem[count[LEVELS-1:0]] <= {item.position, item.item_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      count <= item.is_final ? '0 : count_inc;
    end
  end

  // Build sweep: one internal node a cycle, level by level
  assign off_max = (LEVELS'(1) << lvl) - LEVELS'(1);
  assign node_b  = (LEVELS'(1) << lvl) | off;
  assign lo      = AW'(off) << (LEVELS - int'(lvl));
  assign half    = AW'(1) << (LEVELS - 1 - int'(lvl));
  assign n_ext   = AW'(n_items);
  assign span    = n_ext - lo;
  assign left_b  = (n_ext <= lo) ? '0 : ((span >= half) ? LEVELS'(half) : LEVELS'(span));
  assign build_last = (lvl == LW'(LEVELS - 1)) && (off == off_max);

  // Descent: each node holds the free count of its left subtree
  assign remain_m1 = remain - CW'(1);
  assign pos_e     = CMP_W'(entry_q[POS_W+VAL_W-1:VAL_W]);
  assign im1_e     = CMP_W'(remain_m1);
  assign rank_cur  = (dlev != '0) ? rank :
                     ((pos_e > im1_e) ? LEVELS'(remain_m1)
                                      : LEVELS'(entry_q[POS_W+VAL_W-1:VAL_W]));
  assign go_left   = tree_q > rank_cur;
  assign rank_next = go_left ? rank_cur : rank_cur - tree_q;
  assign child     = LEVELS'({node, !go_left});
  assign desc_last = (dlev == LW'(LEVELS - 1));

  // Advance counters of the run
  always_ff @(posedge clk) begin
    if (cmd.accept && item.is_final) begin
      n_items  <= count_inc;
      remain   <= count_inc;
      emit_idx <= '0;
      lvl      <= '0;
      off      <= '0;
    end
    if (cmd.build_step) begin
      if (off == off_max) begin
        lvl <= lvl + LW'(1);
        off <= '0;
      end else begin
        off <= off + LEVELS'(1);
      end
    end
    if (cmd.fetch) begin
      node    <= LEVELS'(1);
      dlev    <= '0;
      entry_q <= item_mem[remain_m1[LEVELS-1:0]];
    end
    if (cmd.descend) begin
      rank <= rank_next;
      node <= child;
      dlev <= dlev + LW'(1);
      if (desc_last) remain <= remain_m1;
    end
    if (cmd.emit_adv) emit_idx <= emit_idx + CW'(1);
  end

  // Tree memory: one write, one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.build_step) begin
      free_count_tree[node_b] <= left_b;
    end else if (cmd.descend && go_left) begin
      free_count_tree[node] <= tree_q - LEVELS'(1);
    end
    if (cmd.fetch) begin
      tree_q <= free_count_tree[LEVELS'(1)];
    end else if (cmd.descend && !desc_last) begin
      tree_q <= free_count_tree[child];
    end
  end

  // Arranged line: place at the leaf, read back in slot order
  always_ff @(posedge clk) begin
    if (cmd.descend && desc_last) begin
      line_mem[child] <= entry_q[VAL_W-1:0];
    end
    if (cmd.emit_rd) begin
      line_q <= line_mem[emit_idx[LEVELS-1:0]];
    end
  end

  assign sts.build_last = build_last;
  assign sts.desc_last  = desc_last;
  assign sts.last_item  = (remain == CW'(1));
  assign sts.emit_last  = ((emit_idx + CW'(1)) == n_items);

  assign slot.slot_index  = POS_W'(emit_idx);
  assign slot.slot_value  = line_q;
  assign slot.end_of_line = ((emit_idx + CW'(1)) == n_items);

endmodule

`default_nettype wire

### hdl/kth_free_slot_insertion_order_core.sv
// Top level of the free-slot insertion order core.
// Depends on kfs_pkg, kfs_ctrl, kfs_datapath and the assertion macro header.
//
// Usage: items (position, item_value, is_final) arrive on the item channel,
// one beat per cycle while the block is loading. A beat with is_final set
// closes the sequence; beats beyond CAPACITY are dropped, a dropped final
// beat still closes it. The item channel then stalls while the line is
// rebuilt: a build sweep over the L levels of the tree (L = clog2(CAPACITY),
// 6 for 64), then for each of the n stored items one fetch and a descent
// of one tree level a cycle through the tree memory. After that the n
// slots leave on the slot channel in slot order, each beat a registered
// memory read, then a show; end_of_line marks the last.
// A stall on the slot channel holds the current beat and pauses emission.
// Loading resumes the cycle after the last beat is taken. Reset empties the
// item count and returns to loading; the stores need no clearing, as every
// run rewrites each entry before it reads it.
`default_nettype none

`include "kth_free_slot_insertion_order_core_defines.svh"

module kth_free_slot_insertion_order_core #(
  parameter int CAPACITY = 64
) (
  input  wire             clk,
  input  wire             rst,
  input  kfs_pkg::item_t  item,
  input  wire             item_valid,
  output logic            item_stall,
  output kfs_pkg::slot_t  slot,
  output logic            slot_valid,
  input  wire             slot_stall
);

  kfs_pkg::ctrl_cmd_t cmd;
  kfs_pkg::ctrl_sts_t sts;

  // Sequencer
  kfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_final (item.is_final),
    .slot_stall (slot_stall),
    .sts        (sts),
    .item_stall (item_stall),
    .slot_valid (slot_valid),
    .cmd        (cmd)
  );

  // Stores and arithmetic
  kfs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cmd  (cmd),
    .sts  (sts),
    .slot (slot)
  );

  // Checks on the sequencing
  `KFS_ASSERT_IMPL(a_no_overlap, slot_valid, item_stall, "slot beat while loading")
  `KFS_ASSERT_NEXT(a_final_stalls, item_valid && !item_stall && item.is_final, item_stall && !slot_valid, "final beat did not start the run")
  `KFS_ASSERT_NEXT(a_eol_reloads, slot_valid && !slot_stall && slot.end_of_line, !item_stall && !slot_valid, "no return to loading after last slot")

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking bench for kth_free_slot_insertion_order_core: rebuilds each insertion line
// in a local predictor and checks every slot beat against it, under random idling and stalls.
// Depends on kfs_pkg and the core RTL.
`default_nettype none

module tb;

  localparam int POS_W          = kfs_pkg::POS_W;
  localparam int VAL_W          = kfs_pkg::VAL_W;
  localparam int LINE_CAP       = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int RANDOM_ITEMS   = 100;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic           clk;
  logic           rst;
  kfs_pkg::item_t item;
  logic           item_valid;
  logic           item_stall;
  kfs_pkg::slot_t slot;
  logic           slot_valid;
  logic           slot_stall;

  // Predictor state: items of the open sequence and the line still to arrive
  kfs_pkg::item_t seq_store [LINE_CAP];
  int             seq_count;
  kfs_pkg::slot_t line_expected [$];

  int       error_count;
  int       items_sent;
  int       burst_left;
  int       hold_cycles;
  int       idle_cycles;
  int       mode_left;
  rx_mode_t rx_mode;

  kth_free_slot_insertion_order_core #(.CAPACITY(LINE_CAP)) dut (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .slot       (slot),
    .slot_valid (slot_valid),
    .slot_stall (slot_stall)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic kfs_pkg::item_t make_item(logic [POS_W-1:0] p, logic [VAL_W-1:0] v,
                                               logic f);
    kfs_pkg::item_t it;
    it.position   = p;
    it.item_value = v;
    it.is_final   = f;
    return it;
  endfunction

  // Store the beat; on a final beat rebuild the line by walking the items in reverse,
  // each taking the (position+1)-th slot still free, clamped to the last free one
  task automatic absorb_item(input kfs_pkg::item_t beat);
    logic [VAL_W-1:0] line_vals [LINE_CAP];
    bit               taken [LINE_CAP];
    int               i;
    int               k;
    int               rank;
    int               seen;
    int               pick;
    bit               found;
    kfs_pkg::slot_t   s;
    if (seq_count < LINE_CAP) begin
      seq_store[seq_count] = beat;
      seq_count++;
    end
    if (!beat.is_final) return;
    for (k = 0; k < LINE_CAP; k++) taken[k] = 1'b0;
    for (i = seq_count; i > 0; i--) begin
      rank = int'(seq_store[i-1].position);
      if (rank > i - 1) rank = i - 1;
      seen  = 0;
      pick  = 0;
      found = 1'b0;
      for (k = 0; k < seq_count; k++) begin
        if (!taken[k] && !found) begin
          if (seen == rank) begin
            pick  = k;
            found = 1'b1;
          end
          seen++;
        end
      end
      taken[pick]     = 1'b1;
      line_vals[pick] = seq_store[i-1].item_value;
    end
    for (k = 0; k < seq_count; k++) begin
      s.slot_index  = k[POS_W-1:0];
      s.slot_value  = line_vals[k];
      s.end_of_line = (k + 1 == seq_count);
      line_expected.push_back(s);
    end
    seq_count = 0;
  endtask

  // Offer one beat, inserting a random gap whenever a burst runs out
  task automatic send_item(input kfs_pkg::item_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    item       <= beat;
    item_valid <= 1'b1;
    @(negedge clk);
    while (item_stall) @(negedge clk);
    @(posedge clk);
    absorb_item(beat);
    items_sent++;
  endtask

  // Random content; half the positions stay within the items sent so far so that insertions land inside
  task automatic send_sequence(input int len);
    int               k;
    logic [POS_W-1:0] p;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 1) == 0) p = POS_W'($urandom_range(0, 63));
      else                           p = POS_W'($urandom_range(0, (k < 63) ? k : 63));
      send_item(make_item(p, VAL_W'($urandom), (k == len - 1)));
    end
  endtask

  // Receiver: a long hold-off when asked, otherwise a stall pattern that changes mode
  initial begin
    slot_stall <= 1'b0;
    mode_left = 0;
    rx_mode   = RX_OPEN;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        slot_stall <= 1'b1;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 120);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:  slot_stall <= 1'b0;
          RX_LIGHT: slot_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: slot_stall <= ($urandom_range(0, 3) != 0);
          default:  slot_stall <= ~slot_stall;
        endcase
      end
    end
  end

  // Check each slot beat against the oldest expectation; sample mid-cycle
  always @(negedge clk) begin
    if (!rst && slot_valid && !slot_stall) begin
      if (line_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected slot beat index %0d value %h",
                                slot.slot_index, slot.slot_value));
      end else begin
        if (slot.slot_index !== line_expected[0].slot_index)
          flag_mismatch($sformatf("slot_index got %0d want %0d",
                                  slot.slot_index, line_expected[0].slot_index));
        if (slot.slot_value !== line_expected[0].slot_value)
          flag_mismatch($sformatf("slot_value at %0d got %h want %h",
                                  line_expected[0].slot_index, slot.slot_value,
                                  line_expected[0].slot_value));
        if (slot.end_of_line !== line_expected[0].end_of_line)
          flag_mismatch($sformatf("end_of_line at %0d got %b want %b",
                                  line_expected[0].slot_index, slot.end_of_line,
                                  line_expected[0].end_of_line));
        void'(line_expected.pop_front());
      end
    end
  end

  // Watchdog: end the run after too long without any accepted beat
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (rst || (item_valid && !item_stall) || (slot_valid && !slot_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Single final beats, one of them with a position far past the line
  task automatic test_lone_items;
    send_item(make_item(6'd0, 16'hFFFF, 1'b1));
    send_item(make_item(6'd63, 16'h0000, 1'b1));
  endtask

  task automatic test_extreme_fields;
    send_item(make_item(6'd63, 16'h0000, 1'b0));
    send_item(make_item(6'd0, 16'hFFFF, 1'b0));
    send_item(make_item(6'd63, 16'hAAAA, 1'b0));
    send_item(make_item(6'd31, 16'h5555, 1'b0));
    send_item(make_item(6'd0, 16'h0001, 1'b1));
  endtask

  // Every beat at the front: the line comes out reversed
  task automatic test_front_insertion;
    int k;
    for (k = 0; k < 5; k++) send_item(make_item(6'd0, VAL_W'(16'h1000 + k), (k == 4)));
  endtask

  // Positions beyond the free slots clamp to the tail, mixed with real insertions
  task automatic test_tail_clamp;
    send_item(make_item(6'd63, 16'h8001, 1'b0));
    send_item(make_item(6'd40, 16'h8002, 1'b0));
    send_item(make_item(6'd1, 16'h8003, 1'b0));
    send_item(make_item(6'd3, 16'h8004, 1'b0));
    send_item(make_item(6'd2, 16'h8005, 1'b0));
    send_item(make_item(6'd62, 16'h8006, 1'b1));
  endtask

  // Fill the store: a dropped final beat still closes the line, then an exact fit
  task automatic test_store_full;
    send_sequence(LINE_CAP + 1);
    send_sequence(LINE_CAP + 3);
    send_sequence(LINE_CAP);
  endtask

  task automatic test_random_sequences;
    int start;
    int len;
    int pick;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)      len = $urandom_range(1, 10);
      else if (pick < 96) len = $urandom_range(11, 40);
      else                len = $urandom_range(60, 70);
      send_sequence(len);
    end
  endtask

  // Hold the receiver off while the sender keeps offering, so the block backs up
  task automatic test_backpressure;
    hold_cycles = HOLD_OFF_LEN;
    send_sequence(12);
    send_sequence(20);
    send_sequence(3);
  endtask

  initial begin
    rst         <= 1'b1;
    item        <= '0;
    item_valid  <= 1'b0;
    error_count = 0;
    items_sent  = 0;
    burst_left  = 0;
    hold_cycles = 0;
    seq_count   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lone_items();
    test_extreme_fields();
    test_front_insertion();
    test_tail_clamp();
    test_store_full();
    test_random_sequences();
    test_backpressure();
    test_random_sequences();

    // Drain the line, then allow for stray beats
    item_valid <= 1'b0;
    while (line_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

### kth_free_slot_insertion_order_core.f
+incdir+hdl
hdl/kfs_pkg.sv
hdl/kfs_ctrl.sv
hdl/kfs_datapath.sv
hdl/kth_free_slot_insertion_order_core.sv
sim/tb.sv
